[hw/rtl/lgpl_pkg.sv]
`timescale 1ns / 1ps

package lgpl_pkg;

  localparam int CMD_W      = 8;
  localparam int CELLS_W    = 64;
  localparam int ROW_NUM_W  = 6;
  localparam int SIZE_W     = 7;
  localparam int GEN_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BOARD_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATION_COUNT = 2'd2;

  localparam logic [SIZE_W-1:0] BOARD_SIZE_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_UP    = "w";
  localparam logic [CMD_W-1:0] CMD_DOWN  = "s";
  localparam logic [CMD_W-1:0] CMD_LEFT  = "a";
  localparam logic [CMD_W-1:0] CMD_RIGHT = "d";
  localparam logic [CMD_W-1:0] CMD_PEN   = "x";

  localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_FILL,
    ST_ROW,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } lgpl_state_t;

  typedef struct packed {
    logic pen_step;
    logic run_start;
    logic gen_prime;
    logic gen_fill;
    logic gen_row;
    logic emit_first;
    logic emit_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic row_last;
    logic gen_last;
    logic gen_zero;
  } dp_status_t;

endpackage

[hw/rtl/lgpl_cmd_if.sv]
`timescale 1ns / 1ps

interface lgpl_cmd_if
  import lgpl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command_byte;
  logic             finish;

  modport source (output valid, output command_byte, output finish, input ready);
  modport sink (input valid, input command_byte, input finish, output ready);
endinterface

[hw/rtl/lgpl_row_if.sv]
`timescale 1ns / 1ps

interface lgpl_row_if
  import lgpl_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CELLS_W-1:0]   row_cells;
  logic [ROW_NUM_W-1:0] row_number;
  logic                 last_row;

  modport source (output valid, output row_cells, output row_number, output last_row,
                  input ready);
  modport sink (input valid, input row_cells, input row_number, input last_row,
                output ready);
endinterface

[hw/rtl/lgpl_ctrl.sv]
`timescale 1ns / 1ps

module lgpl_ctrl
  import lgpl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_finish,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  lgpl_state_t state;
  lgpl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_finish) begin
            cmd.run_start = 1'b1;
            state_next    = status.gen_zero ? ST_EMIT_RD : ST_PRIME;
          end else begin
            cmd.pen_step = 1'b1;
          end
        end
      end
      ST_PRIME: begin
        cmd.gen_prime = 1'b1;
        state_next    = ST_FILL;
      end
      ST_FILL: begin
        cmd.gen_fill = 1'b1;
        state_next   = ST_ROW;
      end
      ST_ROW: begin
        cmd.gen_row = 1'b1;
        if (status.row_last) begin
          state_next = status.gen_last ? ST_EMIT_RD : ST_PRIME;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_first = 1'b1;
        state_next     = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.row_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/lgpl_datapath.sv]
`timescale 1ns / 1ps

module lgpl_datapath
  import lgpl_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CMD_W-1:0]      command_byte,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic [CELLS_W-1:0]    row_cells,
  output logic [ROW_NUM_W-1:0]  row_number,
  output logic                  last_row
);

  localparam int CUR_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  logic [MAX_COLUMNS-1:0] grid [MAX_ROWS];
  logic [MAX_ROWS-1:0]    row_valid;

  logic [SIZE_W-1:0] board_width;
  logic [SIZE_W-1:0] board_height;
  logic [GEN_W-1:0]  generation_count;

  logic [CUR_W-1:0] col_last;
  logic [ROW_W-1:0] row_last_idx;
  logic [MAX_COLUMNS-1:0] mask;

  logic [CUR_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;
  logic             pen_down;
  logic [CUR_W-1:0] cursor_col_next;
  logic [ROW_W-1:0] cursor_row_next;
  logic             pen_down_next;
  logic [CUR_W-1:0] col_clamped;
  logic [ROW_W-1:0] row_clamped;

  logic [ROW_W-1:0]       y;
  logic [GEN_W-1:0]       gens;
  logic [MAX_COLUMNS-1:0] prev;
  logic [MAX_COLUMNS-1:0] cur_raw;
  logic [MAX_COLUMNS-1:0] rdata;

  logic             rd_en;
  logic [ROW_W:0]   rd_full;
  logic             rd_ok;
  logic [ROW_W-1:0] rd_addr;

  logic                   we;
  logic [ROW_W-1:0]       waddr;
  logic [MAX_COLUMNS-1:0] wdata;
  logic [MAX_COLUMNS-1:0] wmask;
  logic [MAX_COLUMNS-1:0] pen_bit;

  logic [MAX_COLUMNS-1:0] up;
  logic [MAX_COLUMNS-1:0] mid;
  logic [MAX_COLUMNS-1:0] down;
  logic [MAX_COLUMNS-1:0] up_l, up_r, mid_l, mid_r, down_l, down_r;
  logic [MAX_COLUMNS-1:0] alive;
  logic [MAX_COLUMNS-1:0] next_row;
  logic [COUNT_W-1:0]     n;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_width      <= BOARD_SIZE_RESET;
      board_height     <= BOARD_SIZE_RESET;
      generation_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOARD_WIDTH:      board_width      <= cfg_data[SIZE_W-1:0];
        REG_BOARD_HEIGHT:     board_height     <= cfg_data[SIZE_W-1:0];
        REG_GENERATION_COUNT: generation_count <= cfg_data[GEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (board_width == '0) begin
      col_last = '0;
    end else if (board_width > SIZE_W'(MAX_COLUMNS)) begin
      col_last = CUR_W'(MAX_COLUMNS - 1);
    end else begin
      col_last = CUR_W'(board_width - SIZE_W'(1));
    end
    if (board_height == '0) begin
      row_last_idx = '0;
    end else if (board_height > SIZE_W'(MAX_ROWS)) begin
      row_last_idx = ROW_W'(MAX_ROWS - 1);
    end else begin
      row_last_idx = ROW_W'(board_height - SIZE_W'(1));
    end
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      mask[i] = (CUR_W'(i) <= col_last);
    end
  end

  // Cursor clamp, move and pen paint for one command byte.
  always_comb begin
    col_clamped     = (cursor_col > col_last) ? col_last : cursor_col;
    row_clamped     = (cursor_row > row_last_idx) ? row_last_idx : cursor_row;
    cursor_col_next = col_clamped;
    cursor_row_next = row_clamped;
    pen_down_next   = pen_down;
    if (command_byte == CMD_UP && row_clamped != '0) begin
      cursor_row_next = row_clamped - ROW_W'(1);
    end
    if (command_byte == CMD_DOWN && row_clamped < row_last_idx) begin
      cursor_row_next = row_clamped + ROW_W'(1);
    end
    if (command_byte == CMD_LEFT && col_clamped != '0) begin
      cursor_col_next = col_clamped - CUR_W'(1);
    end
    if (command_byte == CMD_RIGHT && col_clamped < col_last) begin
      cursor_col_next = col_clamped + CUR_W'(1);
    end
    if (command_byte == CMD_PEN) begin
      pen_down_next = ~pen_down;
    end
    pen_bit = MAX_COLUMNS'(1) << cursor_col_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      pen_down   <= 1'b0;
    end else if (cmd.pen_step) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      pen_down   <= pen_down_next;
    end
  end

  // One generation step: the three-row window gives the next value of row y.
  always_comb begin
    up     = prev;
    mid    = cur_raw & mask;
    down   = status.row_last ? '0 : (rdata & mask);
    up_l   = up << 1;
    up_r   = up >> 1;
    mid_l  = mid << 1;
    mid_r  = mid >> 1;
    down_l = down << 1;
    down_r = down >> 1;
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      n = COUNT_W'(up_l[i]) + COUNT_W'(up[i]) + COUNT_W'(up_r[i]) + COUNT_W'(mid_l[i])
        + COUNT_W'(mid_r[i]) + COUNT_W'(down_l[i]) + COUNT_W'(down[i])
        + COUNT_W'(down_r[i]);
      alive[i] = (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && mid[i]);
    end
    next_row = (alive & mask) | (cur_raw & ~mask);
  end

  always_comb begin
    rd_en   = cmd.gen_prime | cmd.emit_first | cmd.gen_fill | cmd.emit_next | cmd.gen_row;
    rd_full = '0;
    if (cmd.gen_fill || cmd.emit_next) begin
      rd_full = {1'b0, y} + (ROW_W+1)'(1);
    end else if (cmd.gen_row) begin
      rd_full = {1'b0, y} + (ROW_W+1)'(2);
    end
    rd_ok   = (rd_full < (ROW_W+1)'(MAX_ROWS));
    rd_addr = rd_full[ROW_W-1:0];
  end

  always_comb begin
    we    = 1'b0;
    waddr = y;
    wdata = next_row;
    wmask = '1;
    if (cmd.pen_step && pen_down_next) begin
      we    = 1'b1;
      waddr = cursor_row_next;
      wdata = pen_bit;
      wmask = row_valid[cursor_row_next] ? pen_bit : '1;
    end else if (cmd.gen_row) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        if (wmask[i]) begin
          grid[waddr][i] <= wdata[i];
        end
      end
    end
    if (rd_en) begin
      rdata <= (rd_ok && row_valid[rd_addr]) ? grid[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (we) begin
      row_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y    <= '0;
      gens <= '0;
    end else begin
      if (cmd.gen_prime || cmd.emit_first) begin
        y <= '0;
      end else if (cmd.gen_row || cmd.emit_next) begin
        y <= y + ROW_W'(1);
      end
      if (cmd.run_start) begin
        gens <= '0;
      end else if (cmd.gen_row && status.row_last) begin
        gens <= gens + GEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_prime) begin
      prev <= '0;
    end else if (cmd.gen_row) begin
      prev <= cur_raw & mask;
    end
    if (cmd.gen_fill || cmd.gen_row) begin
      cur_raw <= rdata;
    end
  end

  always_comb begin
    status.row_last = (y == row_last_idx);
    status.gen_last = ((gens + GEN_W'(1)) == generation_count);
    status.gen_zero = (generation_count == '0);
  end

  assign row_cells  = CELLS_W'(rdata & mask);
  assign row_number = ROW_NUM_W'(y);
  assign last_row   = status.row_last;

endmodule

[hw/rtl/life_grid_with_pen_loader_unit.sv]
`timescale 1ns / 1ps
// A command byte is accepted while idle, and one can follow in every cycle while
// the unit stays idle. A finish transaction runs generation_count generations,
// each priming the row window (ST_PRIME, ST_FILL) and then computing the rows in
// ST_ROW; row 0 is then read. Rows leave one per cycle while the sink is ready;
// the next transaction is accepted after the last row. Reset clears the board at
// once via per-row valid flags (no clearing pass); cursor, pen and registers reset.

module life_grid_with_pen_loader_unit
  import lgpl_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lgpl_cmd_if.sink              cmd,
  lgpl_row_if.source            rows
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  lgpl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_finish (cmd.finish),
    .in_ready  (cmd.ready),
    .out_valid (rows.valid),
    .out_ready (rows.ready),
    .status    (dp_status),
    .cmd       (ctrl_cmd)
  );

  lgpl_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command_byte (cmd.command_byte),
    .cmd          (ctrl_cmd),
    .status       (dp_status),
    .row_cells    (rows.row_cells),
    .row_number   (rows.row_number),
    .last_row     (rows.last_row)
  );

endmodule
